// ----- src/rkm_pkg.sv -----
// shared types, constants and pattern tables for the response keyword matcher
// no dependencies
package rkm_pkg;

   localparam int unsigned NUM_WORDS = 5;
   localparam int unsigned TICK_LIMIT_DEFAULT = 60000;
   localparam logic [15:0] TIMEOUT_RESET = 16'd60000;

   // item kinds carried on the request tuser
   typedef enum logic [1:0] {
      OP_BYTE = 2'd0,
      OP_TICK = 2'd1,
      OP_ARM  = 2'd2,
      OP_NONE = 2'd3
   } opcode_type;

   localparam logic [2:0] RESP_TIMEOUT = 3'd0;

   // pattern text, one byte per position, unused positions zero
   localparam logic [7:0] WORD_TEXT [NUM_WORDS][8] = '{
      '{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"A", "L", "R", "E", "A", "D", "Y", 8'h00},
      '{"r", "e", "a", "d", "y", 8'h00, 8'h00, 8'h00},
      '{"F", "A", "I", "L", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] WORD_LEN [NUM_WORDS] = '{3'd2, 3'd7, 3'd5, 3'd4, 3'd5};

   // per-item strobes from the top level to the state holders
   typedef struct packed {
      logic       arm;
      logic       tick;
      logic       rx;
      logic [7:0] rx_byte;
   } ctrl_type;

   // matcher state seen by the top level
   typedef struct packed {
      logic [2:0] pattern_index;
      logic [2:0] match_position;
   } match_stat_type;

endpackage

// ----- src/rkm_timer.sv -----
// tick counter and expiry flag of the response keyword matcher
// depends on rkm_pkg
module rkm_timer #(
   parameter int unsigned TICK_LIMIT = rkm_pkg::TICK_LIMIT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  rkm_pkg::ctrl_type ctrl,
   input  logic [15:0]       timeout_ticks,
   output logic              expired,
   output logic              timeout_hit
);

   localparam logic [15:0] LIMIT = 16'(TICK_LIMIT);

   logic [15:0] tick_count_ff, tick_count_in;
   logic        expired_ff, expired_in;
   logic        below;

   // count ticks until the smaller bound is reached
   always_comb begin
      below         = (tick_count_ff < timeout_ticks) && (tick_count_ff < LIMIT);
      tick_count_in = tick_count_ff;
      expired_in    = expired_ff;
      timeout_hit   = 1'b0;
      if (ctrl.arm) begin
         tick_count_in = '0;
         expired_in    = 1'b0;
      end else if (ctrl.tick && !expired_ff) begin
         if (below) begin
            tick_count_in = tick_count_ff + 16'd1;
         end else begin
            tick_count_in = '0;
            expired_in    = 1'b1;
            timeout_hit   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         expired_ff    <= 1'b0;
      end else begin
         tick_count_ff <= tick_count_in;
         expired_ff    <= expired_in;
      end
   end

   assign expired = expired_ff;

endmodule

// ----- src/rkm_match.sv -----
// pattern scanner: pattern index and match position with one-pass retry logic
// depends on rkm_pkg
module rkm_match (
   input  logic                    clock,
   input  logic                    reset,
   input  rkm_pkg::ctrl_type       ctrl,
   input  logic                    restart,
   output logic                    word_hit,
   output logic [2:0]              word_code,
   output rkm_pkg::match_stat_type stat
);

   logic [2:0] pattern_index_ff, pattern_index_in;
   logic [2:0] match_position_ff, match_position_in;

   // find the first pattern from the current one that takes the byte
   always_comb begin
      logic [2:0] pos;
      logic [2:0] next_pos;
      logic       found;
      logic [2:0] found_p;
      logic [2:0] found_pos;
      found     = 1'b0;
      found_p   = '0;
      found_pos = '0;
      for (int p = rkm_pkg::NUM_WORDS - 1; p >= 0; p--) begin
         pos = (3'(p) == pattern_index_ff) ? match_position_ff : 3'd0;
         if ((3'(p) >= pattern_index_ff) && (pos < rkm_pkg::WORD_LEN[p]) &&
             (rkm_pkg::WORD_TEXT[p][pos] == ctrl.rx_byte)) begin
            found     = 1'b1;
            found_p   = 3'(p);
            found_pos = pos;
         end
      end
      next_pos          = found_pos + 3'd1;
      word_hit          = 1'b0;
      word_code         = found_p + 3'd1;
      pattern_index_in  = pattern_index_ff;
      match_position_in = match_position_ff;
      if (ctrl.arm || restart) begin
         pattern_index_in  = '0;
         match_position_in = '0;
      end else if (ctrl.rx) begin
         if (!found) begin
            pattern_index_in  = '0;
            match_position_in = '0;
         end else if (next_pos == rkm_pkg::WORD_LEN[found_p]) begin
            word_hit          = 1'b1;
            pattern_index_in  = '0;
            match_position_in = '0;
         end else begin
            pattern_index_in  = found_p;
            match_position_in = next_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_index_ff  <= '0;
         match_position_ff <= '0;
      end else begin
         pattern_index_ff  <= pattern_index_in;
         match_position_ff <= match_position_in;
      end
   end

   assign stat.pattern_index  = pattern_index_ff;
   assign stat.match_position = match_position_ff;

endmodule

// ----- src/response_keyword_matcher_core.sv -----
// response keyword matcher top level: input register, result register, timeout register
// depends on rkm_pkg, rkm_timer and rkm_match
// an accepted item is held in the input register and its result is registered in the
// result register; throughput one item per clock while the result register is not stalled,
// set by the combinational pattern compare between the two registers
// reset clears both register valids, match state, tick count, expiry; timeout goes to 60000
module response_keyword_matcher_core #(
   parameter int unsigned TICK_LIMIT = rkm_pkg::TICK_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte [7:0], overrun [8], zero [15:9]
   input  logic [1:0]  req_tuser,   // opcode [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // response_code [2:0], zero [7:3]
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0]         timeout_ticks_ff;
   logic                in_vld_ff;
   rkm_pkg::opcode_type in_op_ff;
   logic [7:0]          in_byte_ff;
   logic                in_ovr_ff;
   logic                out_vld_ff, out_vld_in;
   logic [2:0]          out_code_ff, out_code_in;
   logic                fire;
   logic                expired;
   logic                timeout_hit;
   logic                word_hit;
   logic [2:0]          word_code;
   rkm_pkg::ctrl_type       ctrl;
   rkm_pkg::match_stat_type stat;

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= rkm_pkg::TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ticks_ff <= csr_wr_data;
      end
   end

   // the held item is processed when the result register can take a result
   assign fire       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff   <= rkm_pkg::opcode_type'(req_tuser);
         in_byte_ff <= req_tdata[7:0];
         in_ovr_ff  <= req_tdata[8];
      end
   end

   // decode the held item into strobes
   always_comb begin
      ctrl.arm     = 1'b0;
      ctrl.tick    = 1'b0;
      ctrl.rx      = 1'b0;
      ctrl.rx_byte = in_ovr_ff ? 8'h00 : in_byte_ff;
      unique case (in_op_ff)
         rkm_pkg::OP_BYTE: ctrl.rx   = fire && !expired;
         rkm_pkg::OP_TICK: ctrl.tick = fire;
         rkm_pkg::OP_ARM:  ctrl.arm  = fire;
         default: ;
      endcase
   end

   rkm_timer #(
      .TICK_LIMIT(TICK_LIMIT)
   ) u_timer (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .timeout_ticks (timeout_ticks_ff),
      .expired       (expired),
      .timeout_hit   (timeout_hit)
   );

   rkm_match u_match (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .restart   (timeout_hit),
      .word_hit  (word_hit),
      .word_code (word_code),
      .stat      (stat)
   );

   // result register
   always_comb begin
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_code_in = out_code_ff;
      if (timeout_hit) begin
         out_vld_in  = 1'b1;
         out_code_in = rkm_pkg::RESP_TIMEOUT;
      end else if (word_hit) begin
         out_vld_in  = 1'b1;
         out_code_in = word_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_code_ff <= out_code_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {5'd0, out_code_ff};

   // checks
   a_expired_idle: assert property (@(posedge clock) disable iff (reset)
      expired |-> (stat.pattern_index == 3'd0 && stat.match_position == 3'd0))
      else $error("match state not idle while expired");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      stat.pattern_index < 3'(rkm_pkg::NUM_WORDS))
      else $error("pattern index out of range");

   a_timeout_result: assert property (@(posedge clock) disable iff (reset)
      timeout_hit |=> (rsp_tvalid && rsp_tdata[2:0] == rkm_pkg::RESP_TIMEOUT))
      else $error("timeout did not produce a timeout result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_tready) |-> !(timeout_hit || word_hit))
      else $error("result produced while result register is stalled");

endmodule

// ----- verif/keyword_response_checker.sv -----
`timescale 1ns / 100ps
// checker for the response keyword matcher: follows both streams and the csr port,
// predicts the response codes and compares them; depends on rkm_pkg
module keyword_response_checker #(
   parameter int unsigned TICK_LIMIT = rkm_pkg::TICK_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          mismatch_count,
   output int          codes_pending,
   output int          live_items
);

   // "OK" answers with this code, the later words follow in pattern order
   localparam logic [2:0] RESP_WORD_BASE = 3'd1;

   // predicted block state
   logic [15:0] timeout_ticks;
   logic [2:0]  pat_idx;
   logic [2:0]  match_pos;
   logic [15:0] tick_cnt;
   logic        expired;
   logic [2:0]  expected_codes[$];

   initial begin
      mismatch_count = 0;
      codes_pending  = 0;
      live_items     = 0;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR %0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // one character against the current word, retried on the later words on a miss
   task automatic scan_char(input logic [7:0] ch, output bit emit, output logic [2:0] code);
      bit taken;
      taken = 1'b0;
      emit  = 1'b0;
      code  = rkm_pkg::RESP_TIMEOUT;
      while (!taken && pat_idx < rkm_pkg::NUM_WORDS) begin
         if (match_pos < rkm_pkg::WORD_LEN[pat_idx] &&
             rkm_pkg::WORD_TEXT[pat_idx][match_pos] == ch) begin
            taken = 1'b1;
            if (match_pos + 1 == rkm_pkg::WORD_LEN[pat_idx]) begin
               emit      = 1'b1;
               code      = pat_idx + RESP_WORD_BASE;
               pat_idx   = '0;
               match_pos = '0;
            end else begin
               match_pos = match_pos + 3'd1;
            end
         end else begin
            pat_idx   = pat_idx + 3'd1;
            match_pos = '0;
         end
      end
      // no word wanted it: drop and start over
      if (!taken) begin
         pat_idx   = '0;
         match_pos = '0;
      end
   endtask

   // state update for one accepted item
   task automatic advance_matcher(input rkm_pkg::opcode_type op, input logic [7:0] ch,
                                  input logic ovr, output bit emit, output logic [2:0] code,
                                  output bit live);
      emit = 1'b0;
      code = rkm_pkg::RESP_TIMEOUT;
      live = 1'b1;
      if (op == rkm_pkg::OP_ARM) begin
         tick_cnt  = '0;
         expired   = 1'b0;
         pat_idx   = '0;
         match_pos = '0;
      end else if (expired || op == rkm_pkg::OP_NONE) begin
         live = 1'b0;
      end else if (op == rkm_pkg::OP_TICK) begin
         if (tick_cnt < timeout_ticks && tick_cnt < TICK_LIMIT) begin
            tick_cnt = tick_cnt + 16'd1;
         end else begin
            tick_cnt  = '0;
            expired   = 1'b1;
            pat_idx   = '0;
            match_pos = '0;
            emit      = 1'b1;
         end
      end else begin
         scan_char(ovr ? 8'h00 : ch, emit, code);
      end
   endtask

   // predict on accepted items, compare accepted results
   always @(posedge clock) begin
      bit         emit;
      bit         live;
      logic [2:0] code;
      logic [2:0] want;
      if (reset) begin
         timeout_ticks = rkm_pkg::TIMEOUT_RESET;
         pat_idx       = '0;
         match_pos     = '0;
         tick_cnt      = '0;
         expired       = 1'b0;
         expected_codes.delete();
      end else begin
         if (csr_wr_en)
            timeout_ticks = csr_wr_data;
         if (req_tvalid && req_tready) begin
            advance_matcher(rkm_pkg::opcode_type'(req_tuser), req_tdata[7:0], req_tdata[8],
                            emit, code, live);
            if (emit)
               expected_codes.push_back(code);
            if (live)
               live_items++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_codes.size() == 0) begin
               report_mismatch($sformatf("unexpected result, code %0d", rsp_tdata[2:0]));
            end else begin
               want = expected_codes.pop_front();
               if (rsp_tdata[2:0] !== want || rsp_tdata[7:3] !== 5'd0)
                  report_mismatch($sformatf("response code %0d (data %h), expected %0d",
                                            rsp_tdata[2:0], rsp_tdata, want));
            end
         end
      end
      codes_pending = expected_codes.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// top of the response keyword matcher testbench: clock, reset, item and csr stimulus
// depends on rkm_pkg, response_keyword_matcher_core and keyword_response_checker
module testbench;

   localparam int unsigned LIMIT_TICKS = rkm_pkg::TICK_LIMIT_DEFAULT;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   int          mismatch_count;
   int          codes_pending;
   int          live_items;

   bit gaps_on;
   bit stalls_on;
   int hold_requests;

   response_keyword_matcher_core #(.TICK_LIMIT(LIMIT_TICKS)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   keyword_response_checker #(.TICK_LIMIT(LIMIT_TICKS)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .codes_pending  (codes_pending),
      .live_items     (live_items)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // result side: random stall bursts, plus a long hold on request
   initial begin
      int served;
      served = 0;
      rsp_tready <= 1'b0;
      forever begin
         if (hold_requests != served) begin
            served = hold_requests;
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // offer one item and hold it until taken; returns at a falling edge
   task automatic send_item(input rkm_pkg::opcode_type op, input logic [7:0] ch,
                            input logic ovr);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, ovr, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_item(rkm_pkg::OP_BYTE, s[i], 1'b0);
   endtask

   task automatic send_op(input rkm_pkg::opcode_type op);
      send_item(op, 8'($urandom), 1'($urandom));
   endtask

   // drain, let the pipeline settle, then write the timeout register
   task automatic write_timeout(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (codes_pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // mostly whole or cut-off keywords, some stray bytes, ticks, arms and idle opcodes
   task automatic send_random_item();
      int unsigned pick;
      int unsigned k;
      int unsigned len;
      int unsigned bad;
      logic [7:0]  ch;
      logic        ovr;
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, rkm_pkg::NUM_WORDS - 1);
      if (pick < 50) begin
         len = rkm_pkg::WORD_LEN[k];
         if ($urandom_range(0, 3) == 0)
            len = $urandom_range(1, rkm_pkg::WORD_LEN[k]);
         bad = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : len;
         for (int i = 0; i < len; i++) begin
            ch  = rkm_pkg::WORD_TEXT[k][i];
            ovr = 1'b0;
            if (i == bad) begin
               ch  = 8'($urandom);
               ovr = 1'($urandom);
            end
            send_item(rkm_pkg::OP_BYTE, ch, ovr);
         end
      end else if (pick < 68) begin
         if ($urandom_range(0, 1) == 0)
            ch = rkm_pkg::WORD_TEXT[k][$urandom_range(0, rkm_pkg::WORD_LEN[k] - 1)];
         else
            ch = 8'($urandom);
         ovr = ($urandom_range(0, 7) == 0);
         send_item(rkm_pkg::OP_BYTE, ch, ovr);
      end else if (pick < 82) begin
         send_op(rkm_pkg::OP_TICK);
      end else if (pick < 92) begin
         send_op(rkm_pkg::OP_ARM);
      end else begin
         send_op(rkm_pkg::OP_NONE);
      end
   endtask

   // stimulus and verdict
   initial begin
      logic [15:0] settings[5];
      int          start;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= rkm_pkg::OP_BYTE;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      gaps_on       = 1'b1;
      stalls_on     = 1'b1;
      hold_requests = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: byte extremes, each word, overrun, idle opcode, retry on a later word
      send_item(rkm_pkg::OP_BYTE, 8'hFF, 1'b0);
      send_item(rkm_pkg::OP_BYTE, 8'h00, 1'b0);
      send_text("OK");
      send_item(rkm_pkg::OP_BYTE, "O", 1'b1);
      send_item(rkm_pkg::OP_BYTE, "K", 1'b0);
      send_op(rkm_pkg::OP_NONE);
      send_op(rkm_pkg::OP_TICK);
      send_text("ready");
      send_text("AFAIL");
      send_text("ALREADY");
      send_text("ERROR");

      // zero timeout: first tick expires, then bytes and ticks are ignored until armed
      write_timeout(16'd0);
      send_op(rkm_pkg::OP_ARM);
      send_op(rkm_pkg::OP_TICK);
      send_text("OK");
      send_op(rkm_pkg::OP_TICK);
      send_op(rkm_pkg::OP_ARM);
      send_text("OK");

      // largest timeout: a run of ticks stays below both bounds
      write_timeout(16'hFFFF);
      send_op(rkm_pkg::OP_ARM);
      repeat (20) send_op(rkm_pkg::OP_TICK);
      send_text("FAIL");

      // random phases over several timeouts, with a long result hold in the middle
      settings[0] = 16'd1;
      settings[1] = 16'($urandom_range(2, 40));
      settings[2] = 16'd9;
      settings[3] = rkm_pkg::TIMEOUT_RESET;
      settings[4] = 16'($urandom_range(10, 60));
      for (int ph = 0; ph < 5; ph++) begin
         write_timeout(settings[ph]);
         send_op(rkm_pkg::OP_ARM);
         if (ph == 2) begin
            gaps_on = 1'b0;
            hold_requests++;
            repeat (30) send_text("OK");
            gaps_on = 1'b1;
         end
         if (ph == 4) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         start = live_items;
         while (live_items - start < 60) send_random_item();
      end

      // drain and settle
      req_tvalid <= 1'b0;
      while (codes_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- response_keyword_matcher_core.f -----
src/rkm_pkg.sv
src/rkm_timer.sv
src/rkm_match.sv
src/response_keyword_matcher_core.sv
verif/keyword_response_checker.sv
verif/testbench.sv
